[sv/multi_format_greater_compare_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the multi-format greater compare.
// Each macro expands to a labelled concurrent assertion, or to nothing.
// ----------------------------------------------------------------------------
`ifndef MULTI_FORMAT_GREATER_COMPARE_ASSERT_SVH
`define MULTI_FORMAT_GREATER_COMPARE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define MFGC_ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MFGC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MFGC_ASSERT_IMPL(label, clk, rst, prop, msg)
`define MFGC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[sv/mfgc_pkg.sv]
// ----------------------------------------------------------------------------
// Multi-format greater compare package
// Types, codes and the compare function shared by the block's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mfgc_pkg;

  localparam int unsigned OpW = 32;
  localparam int unsigned TypeW = 3;

  localparam logic [TypeW-1:0] TYPE_FP16 = 3'd0;
  localparam logic [TypeW-1:0] TYPE_FP32 = 3'd1;
  localparam logic [TypeW-1:0] TYPE_I32  = 3'd2;
  localparam logic [TypeW-1:0] TYPE_I8   = 3'd3;
  localparam logic [TypeW-1:0] TYPE_BF16 = 3'd4;

  localparam logic [15:0] FP16_EXP_MASK  = 16'h7C00;
  localparam logic [15:0] FP16_FRAC_MASK = 16'h03FF;
  localparam logic [15:0] BF16_EXP_MASK  = 16'h7F80;
  localparam logic [15:0] BF16_FRAC_MASK = 16'h007F;
  localparam logic [15:0] H16_MAG_MASK   = 16'h7FFF;
  localparam logic [15:0] H16_SIGN_MASK  = 16'h8000;

  typedef struct packed {
    logic [OpW-1:0] first_bits;
    logic [OpW-1:0] second_bits;
  } operands_t;

  typedef struct packed {
    logic is_greater;
  } result_t;

  // Sign-magnitude strictly greater with NaN and signed-zero handling.
  function automatic logic sm_greater(input logic [OpW-1:0] x, input logic [OpW-1:0] y,
                                      input logic [OpW-1:0] exp_mask,
                                      input logic [OpW-1:0] frac_mask);
    logic x_nan;
    logic y_nan;
    logic zeros;
    logic x_neg;
    logic y_neg;
    logic [OpW-1:0] mag_mask;
    logic [OpW-1:0] sign_mask;
    mag_mask  = exp_mask | frac_mask;
    sign_mask = (mag_mask + 1'b1) & ~mag_mask;
    x_nan = ((x & exp_mask) == exp_mask) && ((x & frac_mask) != '0);
    y_nan = ((y & exp_mask) == exp_mask) && ((y & frac_mask) != '0);
    zeros = ((x & mag_mask) == '0) && ((y & mag_mask) == '0);
    x_neg = (x & sign_mask) != '0;
    y_neg = (y & sign_mask) != '0;
    if (x_nan || y_nan || zeros) begin
      return 1'b0;
    end else if (x_neg != y_neg) begin
      return !x_neg;
    end else begin
      return x_neg ? (x < y) : (x > y);
    end
  endfunction

endpackage

`default_nettype wire

[sv/mfgc_stream_if.sv]
// ----------------------------------------------------------------------------
// Multi-format greater compare stream interface
// Valid and ready handshake with a generic payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfgc_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/multi_format_greater_compare.sv]
// ----------------------------------------------------------------------------
// Multi-format greater compare
// The input channel carries two raw operands; the output channel carries one
// result item per input item, set when the first operand is strictly greater
// under the configured format (fp16, fp32, int32, int8 or bf16).
// An accepted item is held in an input register and compared, and the result is
// captured in an output register and presented to the receiver from there.
// One item is taken every cycle while the receiver takes results.
// Each register stage advances when empty or when the stage after it moves, so
// a stall of the receiver backs up through the stages and drops ready; nothing
// is lost. Reset empties both stages and sets the format to fp16.
// The format register is written by cfg_we with cfg_data and should only
// change while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_format_greater_compare_assert.svh"

module multi_format_greater_compare
  import mfgc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [TypeW-1:0]  cfg_data,
  mfgc_stream_if.sink            in_ch,
  mfgc_stream_if.source          out_ch
);

  logic [TypeW-1:0] data_type;
  operands_t        in_reg;
  logic             in_vld;
  result_t          res_next;
  result_t          out_reg;
  logic             out_vld;
  logic             out_adv;
  logic             in_adv;

  assign out_adv = !out_vld || out_ch.ready;
  assign in_adv  = !in_vld || out_adv;
  assign in_ch.ready = in_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_type <= TYPE_FP16;
    end else if (cfg_we) begin
      data_type <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_adv) begin
      in_vld <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv && in_ch.valid) begin
      in_reg <= in_ch.data;
    end
  end

  mfgc_core u_core (
    .data_type (data_type),
    .operands  (in_reg),
    .result    (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (out_adv) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && in_vld) begin
      out_reg <= res_next;
    end
  end

  assign out_ch.valid = out_vld;
  assign out_ch.data  = out_reg;

  `MFGC_ASSERT_IMPL(a_stall_holds_input, clk, rst, (in_vld && !out_adv) |=> in_vld && $stable(in_reg), "Input stage lost an item during a stall.")
  `MFGC_ASSERT_IMPL(a_full_blocks_input, clk, rst, (in_vld && out_vld && !out_ch.ready) |-> !in_ch.ready, "Input accepted while both stages were stalled.")
  `MFGC_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !in_vld && !out_vld, "Stages not empty after reset.")

endmodule

`default_nettype wire

[sv/mfgc_core.sv]
// ----------------------------------------------------------------------------
// Multi-format greater compare core
// Selects the format and forms the compare result for one operand pair.
// ----------------------------------------------------------------------------
`default_nettype none

module mfgc_core
  import mfgc_pkg::*;
(
  input  wire logic [TypeW-1:0] data_type,
  input  wire operands_t        operands,
  output result_t               result
);

  logic [OpW-1:0] a;
  logic [OpW-1:0] b;

  assign a = operands.first_bits;
  assign b = operands.second_bits;

  always_comb begin
    case (data_type)
      TYPE_FP16: begin
        result.is_greater = sm_greater({16'b0, a[15:0]}, {16'b0, b[15:0]},
                                       {16'b0, FP16_EXP_MASK}, {16'b0, FP16_FRAC_MASK});
      end
      TYPE_FP32: begin
        result.is_greater = sm_greater(a, b, 32'h7F80_0000, 32'h007F_FFFF);
      end
      TYPE_I32: begin
        result.is_greater = $signed(a) > $signed(b);
      end
      TYPE_I8: begin
        result.is_greater = $signed(a[7:0]) > $signed(b[7:0]);
      end
      default: begin
        result.is_greater = sm_greater({16'b0, a[15:0]}, {16'b0, b[15:0]},
                                       {16'b0, BF16_EXP_MASK}, {16'b0, BF16_FRAC_MASK});
      end
    endcase
  end

endmodule

`default_nettype wire
